>>> hdl/dfwd_pkg.sv
// Shared constants, types and frame screening function for the deauth flood detector.
package dfwd_pkg;

  // Ring of recent windows
  localparam int ROLL_WINDOWS = 5;
  localparam int POS_W = (ROLL_WINDOWS > 1) ? $clog2(ROLL_WINDOWS) : 1;

  // Field widths
  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 19;
  localparam int ADDR_W  = 48;
  localparam int FC_W    = 8;
  localparam int TICKS_W = 10;

  // Exact ring sum width, wide enough for a full ring of saturated counts
  localparam int SUM_W = $clog2(ROLL_WINDOWS * ((2 ** COUNT_W) - 1) + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd2;

  localparam logic [TOTAL_W-1:0] THRESHOLD_RST = 19'd5;
  localparam logic [TICKS_W-1:0] COOLDOWN_RST  = 10'd30;

  // Frame-control codes
  localparam logic [1:0] FC_TYPE_MGMT    = 2'h0;
  localparam logic [3:0] FC_SUB_DEAUTH   = 4'd12;
  localparam logic [3:0] FC_SUB_DISASSOC = 4'd10;

  // Input beat kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Window close command into the ring
  typedef struct packed {
    logic               push;
    logic [COUNT_W-1:0] count;
  } ring_cmd_t;

  // Ring result for the closing window
  typedef struct packed {
    logic               flood;
    logic [TOTAL_W-1:0] total;
  } ring_res_t;

  // Management deauth or disassoc frame
  function automatic logic frame_counts(input logic mgmt, input logic [FC_W-1:0] fc);
    logic [1:0] ftype;
    logic [3:0] fsub;
    ftype = fc[3:2];
    fsub  = fc[7:4];
    return mgmt && (ftype == FC_TYPE_MGMT) &&
           ((fsub == FC_SUB_DEAUTH) || (fsub == FC_SUB_DISASSOC));
  endfunction

endpackage

>>> hdl/dfwd_if.sv
// Valid/ready channel interfaces for input items and tick results.
interface dfwd_item_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       management_packet;
  logic [dfwd_pkg::FC_W-1:0]  frame_control;
  logic [dfwd_pkg::ADDR_W-1:0] transmitter_address;
  logic [dfwd_pkg::ADDR_W-1:0] bssid_address;

  modport source (output valid, kind, management_packet, frame_control,
                  transmitter_address, bssid_address, input ready);
  modport sink   (input valid, kind, management_packet, frame_control,
                  transmitter_address, bssid_address, output ready);
endinterface

interface dfwd_result_if;
  logic                         valid;
  logic                         ready;
  logic                         alert;
  logic                         flood_detected;
  logic [dfwd_pkg::TOTAL_W-1:0] rolling_total;
  logic [dfwd_pkg::ADDR_W-1:0]  alert_source_address;
  logic [dfwd_pkg::ADDR_W-1:0]  alert_bssid;

  modport source (output valid, alert, flood_detected, rolling_total,
                  alert_source_address, alert_bssid, input ready);
  modport sink   (input valid, alert, flood_detected, rolling_total,
                  alert_source_address, alert_bssid, output ready);
endinterface

>>> hdl/dfwd_ring.sv
// Ring of recent window counts with a running sum and threshold compare.
module dfwd_ring (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dfwd_pkg::ring_cmd_t          cmd,
  input  logic [dfwd_pkg::TOTAL_W-1:0] threshold,
  output dfwd_pkg::ring_res_t          res
);

  logic [dfwd_pkg::COUNT_W-1:0] ring_r [dfwd_pkg::ROLL_WINDOWS];
  logic [dfwd_pkg::POS_W-1:0]   pos_r;
  logic [dfwd_pkg::SUM_W-1:0]   sum_r;
  logic [dfwd_pkg::SUM_W-1:0]   sum_nxt;
  logic [dfwd_pkg::POS_W-1:0]   pos_nxt;

  // Replace the oldest entry in the running sum, then saturate for reporting
  always_comb begin
    sum_nxt = sum_r - dfwd_pkg::SUM_W'(ring_r[pos_r])
                    + dfwd_pkg::SUM_W'(cmd.count);
    if (sum_nxt > dfwd_pkg::SUM_W'(dfwd_pkg::TOTAL_MAX)) begin
      res.total = dfwd_pkg::TOTAL_MAX;
    end else begin
      res.total = dfwd_pkg::TOTAL_W'(sum_nxt);
    end
    res.flood = (res.total >= threshold);
    if (pos_r == dfwd_pkg::POS_W'(dfwd_pkg::ROLL_WINDOWS - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  // Flood wipes the whole ring; otherwise the closing window takes its slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
      for (int i = 0; i < dfwd_pkg::ROLL_WINDOWS; i++) ring_r[i] <= '0;
    end else if (cmd.push) begin
      pos_r <= pos_nxt;
      if (res.flood) begin
        sum_r <= '0;
        for (int i = 0; i < dfwd_pkg::ROLL_WINDOWS; i++) ring_r[i] <= '0;
      end else begin
        sum_r         <= sum_nxt;
        ring_r[pos_r] <= cmd.count;
      end
    end
  end

endmodule

>>> hdl/deauth_flood_window_detector.sv
// Top level of the deauth flood detector: handshake, window counter, cooldown.
//
// Usage: beats on in_item are either sniffed frames (kind 0) or window-end
// ticks (kind 1). Frames that are management deauth/disassoc frames bump the
// current window count and latch their transmitter and BSSID. Each tick
// closes the window and yields exactly one beat on out_res carrying the
// rolling total over the last windows, the flood flag and the alert flag
// (subject to the cooldown counted in ticks). Frames yield no result beat.
// With monitoring disabled every beat is consumed and dropped.
// A tick beat goes from the input register to the result register, which
// presents it on out_res. Throughput: one beat per cycle while out_res does
// not stall; the state update is a single pass of compare, increment and
// ring-sum add between the two registers. Reset (synchronous, rst_n low)
// clears the ring, counters and addresses, loads the register defaults and
// leaves the cooldown expired. When out_res stalls, one tick may wait in the
// result register while one more beat sits in the input register;
// in_item.ready then drops. Registers are written through cfg_we, cfg_index
// and cfg_wdata; the user must write only while idle; the block has no guard.
module deauth_flood_window_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  dfwd_item_if.sink                       in_item,
  dfwd_result_if.source                   out_res,
  input  logic                            cfg_we,
  input  logic [dfwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfwd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [dfwd_pkg::TOTAL_W-1:0] threshold_r;
  logic [dfwd_pkg::TICKS_W-1:0] cooldown_r;
  logic                         enable_r;

  // Input register
  logic                         s1_valid_r;
  logic                         s1_kind_r;
  logic                         s1_mgmt_r;
  logic [dfwd_pkg::FC_W-1:0]    s1_fc_r;
  logic [dfwd_pkg::ADDR_W-1:0]  s1_ta_r;
  logic [dfwd_pkg::ADDR_W-1:0]  s1_bssid_r;

  // Detector state
  logic [dfwd_pkg::COUNT_W-1:0] wcnt_r;
  logic [dfwd_pkg::ADDR_W-1:0]  last_src_r;
  logic [dfwd_pkg::ADDR_W-1:0]  last_bssid_r;
  logic [dfwd_pkg::TICKS_W-1:0] tsa_r;
  logic [dfwd_pkg::TICKS_W-1:0] tsa_nxt;

  // Result register
  logic                         out_valid_r;
  logic                         out_alert_r;
  logic                         out_flood_r;
  logic [dfwd_pkg::TOTAL_W-1:0] out_total_r;
  logic [dfwd_pkg::ADDR_W-1:0]  out_src_r;
  logic [dfwd_pkg::ADDR_W-1:0]  out_bssid_r;

  logic                         proc;
  logic                         counted;
  logic                         alert_nxt;
  logic [dfwd_pkg::TICKS_W-1:0] tsa_inc;
  dfwd_pkg::ring_cmd_t          ring_cmd;
  dfwd_pkg::ring_res_t          ring_res;

  // Stage 1 moves on when the result slot is free or being drained
  assign proc          = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_item.ready = !s1_valid_r || proc;

  assign counted = proc && enable_r && (s1_kind_r == dfwd_pkg::KIND_FRAME) &&
                   dfwd_pkg::frame_counts(s1_mgmt_r, s1_fc_r);
  assign ring_cmd.push  = proc && enable_r && (s1_kind_r == dfwd_pkg::KIND_TICK);
  assign ring_cmd.count = wcnt_r;

  dfwd_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (ring_cmd),
    .threshold (threshold_r),
    .res       (ring_res)
  );

  // Cooldown: count the tick first, then check against the register
  always_comb begin
    tsa_inc   = (tsa_r == dfwd_pkg::TICKS_MAX) ? tsa_r : tsa_r + 1'b1;
    alert_nxt = ring_res.flood && (tsa_inc >= cooldown_r);
    tsa_nxt   = alert_nxt ? '0 : tsa_inc;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= dfwd_pkg::THRESHOLD_RST;
      cooldown_r  <= dfwd_pkg::COOLDOWN_RST;
      enable_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        dfwd_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata;
        dfwd_pkg::CFG_COOLDOWN:  cooldown_r  <= cfg_wdata[dfwd_pkg::TICKS_W-1:0];
        dfwd_pkg::CFG_ENABLE:    enable_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_kind_r  <= in_item.kind;
      s1_mgmt_r  <= in_item.management_packet;
      s1_fc_r    <= in_item.frame_control;
      s1_ta_r    <= in_item.transmitter_address;
      s1_bssid_r <= in_item.bssid_address;
    end
  end

  // Window counter, last addresses and cooldown counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r       <= '0;
      last_src_r   <= '0;
      last_bssid_r <= '0;
      tsa_r        <= dfwd_pkg::TICKS_MAX;
    end else if (ring_cmd.push) begin
      wcnt_r <= '0;
      tsa_r  <= tsa_nxt;
    end else if (counted) begin
      if (wcnt_r != dfwd_pkg::COUNT_MAX) wcnt_r <= wcnt_r + 1'b1;
      last_src_r   <= s1_ta_r;
      last_bssid_r <= s1_bssid_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ring_cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_cmd.push) begin
      out_alert_r <= alert_nxt;
      out_flood_r <= ring_res.flood;
      out_total_r <= ring_res.total;
      out_src_r   <= last_src_r;
      out_bssid_r <= last_bssid_r;
    end
  end

  assign out_res.valid                = out_valid_r;
  assign out_res.alert                = out_alert_r;
  assign out_res.flood_detected       = out_flood_r;
  assign out_res.rolling_total        = out_total_r;
  assign out_res.alert_source_address = out_src_r;
  assign out_res.alert_bssid          = out_bssid_r;

  // Checks
  a_alert_needs_flood: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_alert_r || out_flood_r))
    else $error("alert without flood");

  a_alert_restarts_cooldown: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_cmd.push && alert_nxt) |=> (tsa_r == '0))
    else $error("cooldown not restarted after alert");

  a_tick_clears_window: assert property (@(posedge clk) disable iff (!rst_n)
    ring_cmd.push |=> (wcnt_r == '0))
    else $error("window count not cleared by tick");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> (s1_valid_r && out_valid_r && !out_res.ready))
    else $error("input stalled with space available");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the deauth flood window detector.
module tb_top;

  localparam int STALL_LIMIT = 4000; // cycles with no beat moving on either side
  localparam int SETTLE      = 8;    // covers input and result registers plus a held beat
  localparam int SEG_BEATS   = 140;
  localparam int MAX_PRINTS  = 40;
  localparam int VAL_W       = dfwd_pkg::ADDR_W;

  typedef logic [VAL_W-1:0] val_t;

  // One input beat as the driver presents it
  typedef struct packed {
    logic                        kind;
    logic                        mgmt;
    logic [dfwd_pkg::FC_W-1:0]   fc;
    logic [dfwd_pkg::ADDR_W-1:0] ta;
    logic [dfwd_pkg::ADDR_W-1:0] bss;
  } frame_beat_t;

  // One tick report
  typedef struct packed {
    logic                         alert;
    logic                         flood;
    logic [dfwd_pkg::TOTAL_W-1:0] total;
    logic [dfwd_pkg::ADDR_W-1:0]  src;
    logic [dfwd_pkg::ADDR_W-1:0]  bss;
  } tick_res_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [dfwd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dfwd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  dfwd_item_if   item_ch ();
  dfwd_result_if res_ch ();

  deauth_flood_window_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus and expectations
  frame_beat_t beats_to_send[$];
  tick_res_t   tick_reports_due[$];

  int  tx_idle_pct;
  int  rx_idle_pct;
  bit  beat_taken;
  int  stall_cycles;
  int  error_count;
  int  beats_accepted;
  int  reports_checked;
  int  floods_seen;
  int  alerts_seen;

  // Detector shadow: configuration and state
  logic [dfwd_pkg::TOTAL_W-1:0] cfg_threshold;
  logic [dfwd_pkg::TICKS_W-1:0] cfg_cooldown;
  logic                         cfg_enable;
  logic [dfwd_pkg::COUNT_W-1:0] win_count;
  logic [dfwd_pkg::COUNT_W-1:0] win_ring [dfwd_pkg::ROLL_WINDOWS];
  int                           ring_pos;
  logic [dfwd_pkg::ADDR_W-1:0]  last_src;
  logic [dfwd_pkg::ADDR_W-1:0]  last_bss;
  logic [dfwd_pkg::TICKS_W-1:0] since_alert;

  // Clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string field, input val_t want, input val_t got);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH %s: expected %0h, got %0h", field, want, got);
    error_count++;
  endtask

  function automatic logic [dfwd_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[dfwd_pkg::ADDR_W-1:0];
  endfunction

  task automatic reset_detector();
    cfg_threshold = dfwd_pkg::THRESHOLD_RST;
    cfg_cooldown  = dfwd_pkg::COOLDOWN_RST;
    cfg_enable    = 1'b1;
    win_count     = '0;
    foreach (win_ring[i]) win_ring[i] = '0;
    ring_pos      = 0;
    last_src      = '0;
    last_bss      = '0;
    since_alert   = dfwd_pkg::TICKS_MAX;
  endtask

  // Advance the shadow detector by one accepted beat
  task automatic advance_detector(input frame_beat_t b, output bit has_report,
                                  output tick_res_t r);
    int total;
    has_report = 1'b0;
    r = '0;
    if (!cfg_enable) return;
    if (b.kind == dfwd_pkg::KIND_FRAME) begin
      if (b.mgmt && b.fc[3:2] == dfwd_pkg::FC_TYPE_MGMT &&
          (b.fc[7:4] == dfwd_pkg::FC_SUB_DEAUTH ||
           b.fc[7:4] == dfwd_pkg::FC_SUB_DISASSOC)) begin
        if (win_count != dfwd_pkg::COUNT_MAX) win_count++;
        last_src = b.ta;
        last_bss = b.bss;
      end
      return;
    end
    // window close
    win_ring[ring_pos] = win_count;
    ring_pos = (ring_pos + 1) % dfwd_pkg::ROLL_WINDOWS;
    win_count = '0;
    total = 0;
    foreach (win_ring[i]) total += int'(win_ring[i]);
    if (total > int'(dfwd_pkg::TOTAL_MAX)) total = int'(dfwd_pkg::TOTAL_MAX);
    if (since_alert != dfwd_pkg::TICKS_MAX) since_alert++;
    r.total = total[dfwd_pkg::TOTAL_W-1:0];
    r.src   = last_src;
    r.bss   = last_bss;
    if (total >= int'(cfg_threshold)) begin
      r.flood = 1'b1;
      if (since_alert >= cfg_cooldown) begin
        r.alert = 1'b1;
        since_alert = '0;
      end
      foreach (win_ring[i]) win_ring[i] = '0;
    end
    has_report = 1'b1;
  endtask

  // Register write; only called with the block idle
  task automatic set_reg(input logic [dfwd_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= dfwd_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    case (idx)
      dfwd_pkg::CFG_THRESHOLD: cfg_threshold = val[dfwd_pkg::TOTAL_W-1:0];
      dfwd_pkg::CFG_COOLDOWN:  cfg_cooldown  = val[dfwd_pkg::TICKS_W-1:0];
      dfwd_pkg::CFG_ENABLE:    cfg_enable    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_frame(input logic mgmt, input logic [dfwd_pkg::FC_W-1:0] fc,
                            input logic [dfwd_pkg::ADDR_W-1:0] ta,
                            input logic [dfwd_pkg::ADDR_W-1:0] bss);
    beats_to_send.push_back('{kind: dfwd_pkg::KIND_FRAME, mgmt: mgmt, fc: fc, ta: ta,
                              bss: bss});
  endtask

  // Tick with junk in the frame fields
  task automatic push_tick();
    beats_to_send.push_back('{kind: dfwd_pkg::KIND_TICK, mgmt: 1'($urandom_range(1)),
                              fc: dfwd_pkg::FC_W'($urandom_range(255)),
                              ta: rand_addr(), bss: rand_addr()});
  endtask

  // Mostly deauth/disassoc frames, some noise, about one tick in seven
  task automatic push_random_beat();
    logic [dfwd_pkg::FC_W-1:0] fc;
    if ($urandom_range(99) < 15) begin
      push_tick();
    end else begin
      if ($urandom_range(99) < 70)
        fc = {($urandom_range(1) != 0) ? dfwd_pkg::FC_SUB_DEAUTH : dfwd_pkg::FC_SUB_DISASSOC,
              dfwd_pkg::FC_TYPE_MGMT, 2'($urandom_range(3))};
      else
        fc = dfwd_pkg::FC_W'($urandom_range(255));
      push_frame($urandom_range(9) != 0, fc, rand_addr(), rand_addr());
    end
  endtask

  // Wait until every beat is taken and every report has arrived
  task automatic drain();
    while (beats_to_send.size() != 0 || item_ch.valid || tick_reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random register settings for one segment
  task automatic random_config();
    case ($urandom_range(5))
      0:       set_reg(dfwd_pkg::CFG_THRESHOLD, 1);
      1:       set_reg(dfwd_pkg::CFG_THRESHOLD, $urandom_range(327675, 1));
      default: set_reg(dfwd_pkg::CFG_THRESHOLD, $urandom_range(40, 2));
    endcase
    case ($urandom_range(5))
      0:       set_reg(dfwd_pkg::CFG_COOLDOWN, 0);
      1:       set_reg(dfwd_pkg::CFG_COOLDOWN, 1023);
      2:       set_reg(dfwd_pkg::CFG_COOLDOWN, $urandom_range(1023));
      default: set_reg(dfwd_pkg::CFG_COOLDOWN, $urandom_range(8, 1));
    endcase
    set_reg(dfwd_pkg::CFG_ENABLE, 1);
  endtask

  // Input driver: changes at the falling edge, holds a beat until taken
  always @(negedge clk) begin : drive_items
    frame_beat_t b;
    if (!rst_n) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || beat_taken) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        b = beats_to_send.pop_front();
        item_ch.kind                <= b.kind;
        item_ch.management_packet   <= b.mgmt;
        item_ch.frame_control       <= b.fc;
        item_ch.transmitter_address <= b.ta;
        item_ch.bssid_address       <= b.bss;
        item_ch.valid               <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
    res_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  // Monitor, predictor and watchdog at the rising edge
  always @(posedge clk) begin : watch_ports
    tick_res_t   got;
    tick_res_t   want;
    frame_beat_t b;
    bit          has_report;
    bit          res_taken;
    if (!rst_n) begin
      beat_taken = 1'b0;
    end else begin
      beat_taken = item_ch.valid && item_ch.ready;
      res_taken  = res_ch.valid && res_ch.ready;
      // result check against the oldest expectation
      if (res_taken) begin
        got = '{alert: res_ch.alert, flood: res_ch.flood_detected, total: res_ch.rolling_total,
                src: res_ch.alert_source_address, bss: res_ch.alert_bssid};
        if (tick_reports_due.size() == 0) begin
          report_mismatch("report with none pending", '0, val_t'(got.total));
        end else begin
          want = tick_reports_due.pop_front();
          reports_checked++;
          if (want.flood) floods_seen++;
          if (want.alert) alerts_seen++;
          if (got.alert !== want.alert)
            report_mismatch("alert", val_t'(want.alert), val_t'(got.alert));
          if (got.flood !== want.flood)
            report_mismatch("flood_detected", val_t'(want.flood), val_t'(got.flood));
          if (got.total !== want.total)
            report_mismatch("rolling_total", val_t'(want.total), val_t'(got.total));
          if (got.src !== want.src)
            report_mismatch("alert_source_address", want.src, got.src);
          if (got.bss !== want.bss) report_mismatch("alert_bssid", want.bss, got.bss);
        end
      end
      // prediction for the accepted beat
      if (beat_taken) begin
        beats_accepted++;
        b = '{kind: item_ch.kind, mgmt: item_ch.management_packet, fc: item_ch.frame_control,
              ta: item_ch.transmitter_address, bss: item_ch.bssid_address};
        advance_detector(b, has_report, want);
        if (has_report) tick_reports_due.push_back(want);
      end
      // watchdog
      if (beat_taken || res_taken) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Sequence of phases
  initial begin : run_phases
    int ph;
    int seg;
    int n;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    item_ch.valid  = 1'b0;
    item_ch.kind   = 1'b0;
    item_ch.management_packet   = 1'b0;
    item_ch.frame_control       = '0;
    item_ch.transmitter_address = '0;
    item_ch.bssid_address       = '0;
    res_ch.ready   = 1'b0;
    tx_idle_pct    = 17;
    rx_idle_pct    = 86;
    beat_taken     = 1'b0;
    stall_cycles   = 0;
    error_count    = 0;
    beats_accepted = 0;
    reports_checked = 0;
    floods_seen    = 0;
    alerts_seen    = 0;
    reset_detector();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (ph = 0; ph < 3; ph++) begin
      @(posedge clk);
      tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 86 : 0;
      rx_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 17 : 0;

      if (ph == 0) begin
        // directed: reset settings, tick before any counted frame
        push_tick();
        push_frame(1'b0, 8'hC0, '1, '1);          // not management
        push_frame(1'b1, 8'hC4, '1, '1);          // type 1
        push_frame(1'b1, 8'hA8, '1, '1);          // type 2
        push_frame(1'b1, 8'hCC, '1, '1);          // type 3
        push_frame(1'b1, 8'hB0, '1, '1);          // other subtype
        push_frame(1'b1, 8'h00, '1, '1);
        push_frame(1'b1, 8'hFF, '1, '1);
        push_frame(1'b1, 8'hC0, '1, '0);          // deauth
        push_frame(1'b1, 8'hA3, '0, '1);          // disassoc, low bits set
        push_frame(1'b1, 8'hC1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
        push_frame(1'b1, 8'hA2, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        push_tick();                               // total 4, below threshold
        push_frame(1'b1, 8'hC0, rand_addr(), rand_addr());
        push_tick();                               // reaches threshold, alert
        for (n = 0; n < 5; n++) push_frame(1'b1, 8'hA0, rand_addr(), rand_addr());
        push_tick();                               // flood inside cooldown
        push_tick();
        drain();

        // threshold zero with no cooldown: every tick alerts
        set_reg(dfwd_pkg::CFG_THRESHOLD, 0);
        set_reg(dfwd_pkg::CFG_COOLDOWN, 0);
        push_tick();
        push_frame(1'b1, 8'hC0, rand_addr(), rand_addr());
        push_tick();
        push_tick();
        drain();

        // threshold of one, longest cooldown: floods held back
        set_reg(dfwd_pkg::CFG_THRESHOLD, 1);
        set_reg(dfwd_pkg::CFG_COOLDOWN, 1023);
        for (n = 0; n < 3; n++) begin
          push_frame(1'b1, 8'hAC, rand_addr(), rand_addr());
          push_tick();
        end
        drain();
      end

      for (seg = 0; seg < 4; seg++) begin
        random_config();
        for (n = 0; n < SEG_BEATS; n++) push_random_beat();
        drain();
      end

      // monitoring off: everything dropped
      set_reg(dfwd_pkg::CFG_ENABLE, 0);
      for (n = 0; n < 15; n++) push_random_beat();
      drain();
      set_reg(dfwd_pkg::CFG_ENABLE, 1);
    end

    $display("Run covered %0d accepted beats and %0d tick reports (%0d floods, %0d alerts),",
             beats_accepted, reports_checked, floods_seen, alerts_seen);
    $display("over three idling patterns, register extremes and monitoring switched off.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/dfwd_pkg.sv
hdl/dfwd_if.sv
hdl/dfwd_ring.sv
hdl/deauth_flood_window_detector.sv
test/tb_top.sv
